/* rtl/lss_pkg.sv */
// Shared types, field widths and step codes for the latency sample statistics block.
`timescale 1ns / 1ps

package lss_pkg;

	localparam int RTT_W = 24;
	localparam int CNT_W = 11;

	typedef logic [2:0] op_t;

	localparam op_t OP_DIV_SUM = 3'd0;
	localparam op_t OP_MUL_D   = 3'd1;
	localparam op_t OP_DIV_D   = 3'd2;
	localparam op_t OP_MUL_KB  = 3'd3;
	localparam op_t OP_MUL_RR  = 3'd4;
	localparam op_t OP_SQRT    = 3'd5;

	typedef struct packed {
		logic [RTT_W-1:0] rtt_us;
		logic             last_sample;
	} sample_t;

	typedef struct packed {
		logic [CNT_W-1:0] sample_count;
		logic [RTT_W-1:0] mean_rtt;
		logic [RTT_W-1:0] min_rtt;
		logic [RTT_W-1:0] max_rtt;
		logic [RTT_W-1:0] jitter_us;
		logic             overflowed;
	} result_t;

	typedef struct packed {
		logic load;
		logic acc;
		logic start;
		logic capture;
		logic emit;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
		logic done;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* rtl/lss_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lss_div #(
	parameter int N_W = 58,
	parameter int D_W = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo,
	output logic [D_W-1:0] rem
);

	localparam int C_W = $clog2(N_W + 1);

	logic           busy_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] den_q;
	logic [D_W:0]   trial;
	logic [D_W:0]   diff;
	logic           take;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign take  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], take};
			rem_q <= take ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/lss_mul.sv */
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module lss_mul #(
	parameter int A_W = 24,
	parameter int B_W = 35
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     op_a,
	input  logic [B_W-1:0]     op_b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int P_W = A_W + B_W;
	localparam int C_W = $clog2(A_W + 1);

	logic           busy_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [A_W-1:0] a_q;
	logic [P_W-1:0] b_q;
	logic [P_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(A_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= P_W'(op_b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/lss_datapath.sv */
// Accumulators, shared divide and multiply units, square root and result register.
`timescale 1ns / 1ps

module lss_datapath import lss_pkg::*; #(
	parameter int MAX_SAMPLES = 1024,
	parameter int RTT_BITS    = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sample_t   in_data,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts,
	input  logic      out_ready,
	output logic      out_valid,
	output result_t   out_data
);

	localparam int SW   = (RTT_BITS < RTT_W) ? RTT_BITS : RTT_W;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SW + CW;
	localparam int SQW  = 2 * SW + CW;
	localparam int MA   = (SW > CW) ? SW : CW;
	localparam int MB   = SUMW + 1;
	localparam int PW   = MA + MB;
	localparam int VW   = SQW + (SQW % 2);

	logic [SW-1:0]   x_q;
	logic            last_q;
	logic [CW-1:0]   count_q;
	logic [SUMW-1:0] sum_q;
	logic [SQW-1:0]  sumsq_q;
	logic [SW-1:0]   min_q;
	logic [SW-1:0]   max_q;
	logic            ovf_q;
	logic [2*SW-1:0] sq;

	logic [SW-1:0]   q_q;
	logic [CW-1:0]   r_q;
	logic [SQW-1:0]  d_q;
	logic [SQW-1:0]  a_q;
	logic [CW-1:0]   b_q;
	logic [PW-1:0]   kb_q;
	logic [SQW-1:0]  var_q;

	logic [VW-1:0]   v_q;
	logic [VW-1:0]   res_q;
	logic [VW-1:0]   bit_q;
	logic [VW-1:0]   trial;
	logic            sqrt_busy_q;
	logic            sqrt_done_q;

	result_t         out_q;
	logic            out_valid_q;

	logic            div_start;
	logic [SQW-1:0]  div_num;
	logic            div_done;
	logic [SQW-1:0]  div_quo;
	logic [CW-1:0]   div_rem;
	logic            mul_start;
	logic [MA-1:0]   mul_a;
	logic [MB-1:0]   mul_b;
	logic            mul_done;
	logic [PW-1:0]   mul_prod;

	assign sq = x_q * x_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = SQW'(sum_q);
		mul_start = 1'b0;
		mul_a     = MA'(q_q);
		mul_b     = MB'(sum_q) + MB'(r_q);
		case (cmd.op)
			OP_DIV_SUM: begin
				div_start = cmd.start;
			end
			OP_DIV_D: begin
				div_start = cmd.start;
				div_num   = d_q;
			end
			OP_MUL_D: begin
				mul_start = cmd.start;
			end
			OP_MUL_KB: begin
				mul_start = cmd.start;
				mul_a     = MA'(b_q);
				mul_b     = MB'(count_q);
			end
			OP_MUL_RR: begin
				mul_start = cmd.start;
				mul_a     = MA'(r_q);
				mul_b     = MB'(r_q);
			end
			default: begin
			end
		endcase
	end

	lss_div #(
		.N_W(SQW),
		.D_W(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (count_q),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	lss_mul #(
		.A_W(MA),
		.B_W(MB)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.op_a  (mul_a),
		.op_b  (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			min_q       <= '1;
			max_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				if (count_q == CW'(MAX_SAMPLES)) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
					sum_q   <= sum_q + SUMW'(x_q);
					sumsq_q <= sumsq_q + SQW'(sq);
					if (x_q < min_q) begin
						min_q <= x_q;
					end
					if (x_q > max_q) begin
						max_q <= x_q;
					end
				end
			end
			if (cmd.emit) begin
				count_q     <= '0;
				sum_q       <= '0;
				sumsq_q     <= '0;
				min_q       <= '1;
				max_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= in_data.rtt_us[SW-1:0];
			last_q <= in_data.last_sample;
		end
		if (cmd.capture) begin
			case (cmd.op)
				OP_DIV_SUM: begin
					q_q <= div_quo[SW-1:0];
					r_q <= div_rem;
				end
				OP_MUL_D: begin
					d_q <= sumsq_q - mul_prod[SQW-1:0];
				end
				OP_DIV_D: begin
					a_q <= div_quo;
					b_q <= div_rem;
				end
				OP_MUL_KB: begin
					kb_q <= mul_prod;
				end
				OP_MUL_RR: begin
					if (kb_q >= mul_prod || a_q == '0) begin
						var_q <= a_q;
					end else begin
						var_q <= a_q - SQW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			out_q.sample_count <= CNT_W'(count_q);
			out_q.mean_rtt     <= RTT_W'(q_q);
			out_q.min_rtt      <= RTT_W'(min_q);
			out_q.max_rtt      <= RTT_W'(max_q);
			out_q.jitter_us    <= RTT_W'(res_q);
			out_q.overflowed   <= ovf_q;
		end
	end

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_busy_q <= 1'b0;
			sqrt_done_q <= 1'b0;
		end else begin
			sqrt_done_q <= 1'b0;
			if (cmd.start && cmd.op == OP_SQRT) begin
				sqrt_busy_q <= 1'b1;
			end else if (sqrt_busy_q && bit_q[0]) begin
				sqrt_busy_q <= 1'b0;
				sqrt_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == OP_SQRT) begin
			v_q   <= VW'(var_q);
			res_q <= '0;
			bit_q <= {2'b01, {(VW-2){1'b0}}};
		end else if (sqrt_busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.last     = last_q;
	assign sts.done     = div_done | mul_done | sqrt_done_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/lss_ctrl.sv */
// Controller state machine that sequences accumulation and the end-of-set steps.
`timescale 1ns / 1ps

module lss_ctrl import lss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output ctrl_cmd_t cmd,
	input  ctrl_sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACC   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	op_t        step_q;
	op_t        step_d;

	function automatic op_t next_step(input op_t cur);
		case (cur)
			OP_DIV_SUM: next_step = OP_MUL_D;
			OP_MUL_D:   next_step = OP_DIV_D;
			OP_DIV_D:   next_step = OP_MUL_KB;
			OP_MUL_KB:  next_step = OP_MUL_RR;
			OP_MUL_RR:  next_step = OP_SQRT;
			default:    next_step = OP_SQRT;
		endcase
	endfunction

	always_comb begin
		cmd      = '0;
		cmd.op   = step_q;
		in_ready = (state_q == S_IDLE);
		state_d  = state_q;
		step_d   = step_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (sts.last) begin
					step_d  = OP_DIV_SUM;
					state_d = S_START;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_WAIT;
			end
			S_WAIT: begin
				if (sts.done) begin
					cmd.capture = 1'b1;
					if (step_q == OP_SQRT) begin
						state_d = S_EMIT;
					end else begin
						step_d  = next_step(step_q);
						state_d = S_START;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= OP_DIV_SUM;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* rtl/latency_sample_statistics.sv */
// Top level of the latency sample statistics block: controller plus datapath.
//
//   channel   direction   handshake              beat payload
//   in        input       in_valid / in_ready    sample_t: rtt_us, last_sample
//   out       output      out_valid / out_ready  result_t: count, mean, min, max, jitter, flag
//
// A sample that does not end a set is accepted, then accumulated.
// The sample that ends a set is also run through the end-of-set steps on the serial divider,
// multiplier and square root, with SW = min(RTT_BITS,24), SQW = 2*SW + clog2(MAX_SAMPLES+1),
// VW = SQW made even and MA = max(SW, clog2(MAX_SAMPLES+1)) as the datapath widths.
// Reset clears all accumulators at once; no clearing pass follows it.
// A held result blocks the input only when the next set ends before that beat is taken.
`timescale 1ns / 1ps

module latency_sample_statistics import lss_pkg::*; #(
	parameter int MAX_SAMPLES = 1024,
	parameter int RTT_BITS    = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	lss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	lss_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.RTT_BITS   (RTT_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule
